// File: sv/boxcar_moving_average_defines.svh
// Assertion macros used by the boxcar moving average RTL.
`ifndef BOXCAR_MOVING_AVERAGE_DEFINES_SVH
`define BOXCAR_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BMA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bma assertion failed");

// Next-cycle implication, checked outside reset
`define BMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bma assertion failed");

`endif

// File: sv/bma_pkg.sv
// Shared constants for the boxcar moving average filter.
`default_nettype none
package bma_pkg;
  localparam int SAMPLE_BITS        = 16;
  localparam int WIN_BITS           = 9;
  localparam int MAX_WINDOW_DEFAULT = 256;
  localparam logic [WIN_BITS-1:0] WINDOW_RESET = 9'd100;
endpackage
`default_nettype wire

// File: sv/bma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/bma_div.sv
// Bit-serial signed divider: one quotient bit per cycle, truncates toward zero.
`default_nettype none
module bma_div #(
  parameter int SUM_BITS = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic signed [SUM_BITS-1:0]          dividend,
  input  wire logic        [bma_pkg::WIN_BITS-1:0] divisor,
  output logic                                     busy,
  output logic signed [bma_pkg::SAMPLE_BITS-1:0]   quotient
);
  import bma_pkg::*;

  localparam int CNT_BITS = $clog2(SUM_BITS + 1);

  logic [SUM_BITS-1:0] dvd;      // dividend bits shift out, quotient bits shift in
  logic [WIN_BITS-1:0] rem;
  logic [WIN_BITS-1:0] dsr;
  logic                neg;
  logic [CNT_BITS-1:0] count;

  logic [WIN_BITS:0]   rem_shift;
  logic                qbit;
  logic [WIN_BITS:0]   rem_diff;
  logic [SUM_BITS-1:0] quo_signed;

  // One restoring step
  always_comb begin
    rem_shift = {rem, dvd[SUM_BITS-1]};
    rem_diff  = rem_shift - {1'b0, dsr};
    qbit      = (rem_shift >= {1'b0, dsr});
  end

  assign busy       = (count != '0);
  assign quo_signed = neg ? (~dvd + 1'b1) : dvd;
  assign quotient   = quo_signed[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_BITS'(SUM_BITS);
      neg   <= dividend[SUM_BITS-1];
      dvd   <= dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
      rem   <= '0;
      dsr   <= divisor;
    end else if (busy) begin
      count <= count - 1'b1;
      dvd   <= {dvd[SUM_BITS-2:0], qbit};
      rem   <= qbit ? rem_diff[WIN_BITS-1:0] : rem_shift[WIN_BITS-1:0];
    end
  end
endmodule
`default_nettype wire

// File: sv/boxcar_moving_average.sv
// Boxcar moving average: top level with sample ring, running sum and control.
// A priming sample is written straight into the ring; the next sample may follow at once.
// A primed sample starts the bit-serial divider, one quotient bit per cycle, on the
// running sum as it stood at the transfer, then passes S_UPDATE and S_DIV; the mean
// is loaded once the divider is done and the output is free, and only then is the next input taken.
// Synchronous reset clears the stream and sets the window length to 100.
`default_nettype none
`include "boxcar_moving_average_defines.svh"
module boxcar_moving_average #(
  parameter int MAX_WINDOW = bma_pkg::MAX_WINDOW_DEFAULT
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // window length register
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic        [bma_pkg::WIN_BITS-1:0]     window_length,
  // sample input
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [bma_pkg::SAMPLE_BITS-1:0]  sample_value,
  input  wire logic                                    last_sample,
  // average output
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [bma_pkg::SAMPLE_BITS-1:0]       average_value
);
  import bma_pkg::*;

  localparam int POS_BITS = $clog2(MAX_WINDOW);
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);

  typedef enum logic [1:0] {S_IDLE, S_UPDATE, S_DIV} state_t;

  state_t               state;
  logic [WIN_BITS-1:0]  win_reg;
  logic [POS_BITS-1:0]  pos;
  logic signed [SUM_BITS-1:0] running_sum;
  logic [WIN_BITS-1:0]  primed_count;
  logic [SAMPLE_BITS-1:0] sample_hold;
  logic                 last_hold;

  logic [WIN_BITS-1:0]  w_eff;
  logic                 in_xfer;
  logic                 priming;
  logic [POS_BITS:0]    pos_inc;
  logic [POS_BITS-1:0]  pos_next;
  logic                 ram_we;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                 div_start;
  logic                 div_busy;
  logic signed [SAMPLE_BITS-1:0] div_quot;
  logic                 out_free;
  logic                 load_out;
  logic                 pos_ok;
  logic signed [SUM_BITS-1:0] sum_next;

  // Effective window: zero means one, saturate at ring depth
  always_comb begin
    if (win_reg == '0) begin
      w_eff = WIN_BITS'(1);
    end else if (int'(win_reg) > MAX_WINDOW) begin
      w_eff = WIN_BITS'(MAX_WINDOW);
    end else begin
      w_eff = win_reg;
    end
  end

  // Handshakes and ring pointer step; a pending window write holds off samples
  assign cfg_ready = (state == S_IDLE);
  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign in_xfer   = in_valid && !in_stall;
  assign priming   = (primed_count < w_eff);
  assign pos_inc   = {1'b0, pos} + 1'b1;
  assign pos_next  = (pos_inc >= (POS_BITS+1)'(w_eff)) ? '0 : pos_inc[POS_BITS-1:0];
  assign out_free  = !out_valid || !out_stall;
  assign load_out  = (state == S_DIV) && !div_busy && out_free;
  assign div_start = in_xfer && !priming;

  // Ring pointer stays inside the window
  assign pos_ok = ((POS_BITS+1)'(pos) < (POS_BITS+1)'(w_eff))
               || ((w_eff > WIN_BITS'(MAX_WINDOW - 1)) && (int'(pos) < MAX_WINDOW));

  // Ring write: direct while priming, held sample on replacement
  assign ram_we    = (in_xfer && priming) || (state == S_UPDATE);
  assign ram_wdata = (state == S_UPDATE) ? sample_hold : sample_value;

  // Replace the oldest sample in the sum
  assign sum_next = running_sum
                  - {{(SUM_BITS-SAMPLE_BITS){ram_rdata[SAMPLE_BITS-1]}}, ram_rdata}
                  + {{(SUM_BITS-SAMPLE_BITS){sample_hold[SAMPLE_BITS-1]}}, sample_hold};

  bma_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pos),
    .wdata(ram_wdata),
    .raddr(pos),
    .rdata(ram_rdata)
  );

  bma_div #(
    .SUM_BITS(SUM_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(running_sum),
    .divisor (w_eff),
    .busy    (div_busy),
    .quotient(div_quot)
  );

  // Control, stream state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      win_reg      <= WINDOW_RESET;
      pos          <= '0;
      running_sum  <= '0;
      primed_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            win_reg      <= window_length;
            pos          <= '0;
            running_sum  <= '0;
            primed_count <= '0;
          end else if (in_xfer) begin
            sample_hold <= sample_value;
            last_hold   <= last_sample;
            if (priming) begin
              if (last_sample) begin
                pos          <= '0;
                running_sum  <= '0;
                primed_count <= '0;
              end else begin
                pos          <= pos_next;
                running_sum  <= running_sum
                              + {{(SUM_BITS-SAMPLE_BITS){sample_value[SAMPLE_BITS-1]}},
                                 sample_value};
                primed_count <= primed_count + 1'b1;
              end
            end else begin
              state <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          state <= S_DIV;
          if (last_hold) begin
            pos          <= '0;
            running_sum  <= '0;
            primed_count <= '0;
          end else begin
            pos         <= pos_next;
            running_sum <= sum_next;
          end
        end
        S_DIV: begin
          if (load_out) begin
            out_valid     <= 1'b1;
            average_value <= div_quot;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `BMA_ASSERT_NOW(a_count_le_window, clk, rst, 1'b1, primed_count <= w_eff)
  `BMA_ASSERT_NOW(a_pos_in_window, clk, rst, 1'b1, pos_ok)
  `BMA_ASSERT_NOW(a_idle_div_quiet, clk, rst, state == S_IDLE, !div_busy)
  `BMA_ASSERT_NEXT(a_result_loaded, clk, rst, load_out, out_valid && state == S_IDLE)
endmodule
`default_nettype wire
